// ----- rtl/mft_pkg.sv -----
`default_nettype none

package mft_pkg;

    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_TICK   = 2'd1,
        OP_ENABLE = 2'd2,
        OP_STOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_ANGLE_COEF     = 2'd0,
        CFG_SPEED_SMOOTH   = 2'd1,
        CFG_CURRENT_SMOOTH = 2'd2,
        CFG_TIMEOUT_RELOAD = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] RESET_ANGLE_COEF     = 16'd2880;
    localparam logic [16:0] RESET_SPEED_SMOOTH   = 17'd55706;
    localparam logic [16:0] RESET_CURRENT_SMOOTH = 17'd58982;
    localparam logic [7:0]  RESET_TIMEOUT        = 8'd2;

    localparam logic [16:0]        ONE_Q16        = 17'd65536;
    localparam logic signed [16:0] WRAP_THRESHOLD = 17'sd4096;
    localparam logic signed [24:0] DEG_PER_TURN   = 25'sd360;

    localparam logic [1:0] QUEUE_FULL = 2'd2;

    // one decoded command waiting for the back end
    typedef struct packed {
        op_t               op;
        logic [15:0]       ecd;
        logic signed [15:0] rpm;
        logic signed [15:0] cur;
        logic [7:0]        temp;
    } cmd_t;

    // state as seen right after a command has been applied
    typedef struct packed {
        logic [15:0]        position;
        logic signed [15:0] turns;
        logic signed [26:0] speed;
        logic signed [23:0] current;
        logic [7:0]         temp;
        logic               stopped;
    } snap_t;

    typedef struct packed {
        logic [15:0] angle_coef;
        logic [16:0] speed_smooth;
        logic [16:0] current_smooth;
        logic [7:0]  timeout_reload;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/mft_front.sv -----
`default_nettype none

module mft_front
    import mft_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    output logic             head_valid,
    input  wire logic        head_ready,
    output cmd_t             head
);

    cmd_t        queue_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    cmd_t        decoded;
    logic        push, pop;

    // payload is big-endian: byte 0 sits in the top bits
    always_comb begin
        decoded.op   = op_t'(s_tuser);
        decoded.ecd  = s_tdata[63:48];
        decoded.rpm  = s_tdata[47:32];
        decoded.cur  = s_tdata[31:16];
        decoded.temp = s_tdata[15:8];
    end

    assign s_tready   = (count_reg != QUEUE_FULL);
    assign head_valid = (count_reg != 2'd0);
    assign head       = queue_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = head_valid && head_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mft_back.sv -----
`default_nettype none

module mft_back
    import mft_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  cfg_t      cfg,
    input  wire logic head_valid,
    output logic      head_ready,
    input  cmd_t      head,
    output logic      snap_valid,
    input  wire logic snap_ready,
    output snap_t     snap
);

    logic [15:0]        position_reg, position_next;
    logic signed [15:0] turns_reg, turns_next;
    logic signed [27:0] speed_acc_reg, speed_acc_next;
    logic signed [24:0] current_acc_reg, current_acc_next;
    logic [7:0]         temp_reg, temp_next;
    logic [7:0]         timeout_reg, timeout_next;
    logic               stop_reg, stop_next;
    logic               snap_valid_reg, snap_valid_next;
    snap_t              snap_reg, snap_next;

    logic               pop;
    logic [16:0]        speed_coef, current_coef;
    logic signed [28:0] speed_sample, speed_diff;
    logic signed [46:0] speed_prod;
    logic signed [25:0] current_sample, current_diff;
    logic signed [43:0] current_prod;
    logic signed [16:0] delta;

    assign head_ready = !snap_valid_reg || snap_ready;
    assign pop        = head_valid && head_ready;

    // weights above one behave as one
    assign speed_coef   = cfg.speed_smooth[16]   ? ONE_Q16 : cfg.speed_smooth;
    assign current_coef = cfg.current_smooth[16] ? ONE_Q16 : cfg.current_smooth;

    // rpm * 6 * 256 = rpm * 1536
    assign speed_sample = ({{13{head.rpm[15]}}, head.rpm} <<< 10)
                        + ({{13{head.rpm[15]}}, head.rpm} <<< 9);
    assign speed_diff   = speed_sample - {speed_acc_reg[27], speed_acc_reg};
    assign speed_prod   = $signed({1'b0, speed_coef}) * speed_diff;

    assign current_sample = {{2{head.cur[15]}}, head.cur, 8'd0};
    assign current_diff   = current_sample - {current_acc_reg[24], current_acc_reg};
    assign current_prod   = $signed({1'b0, current_coef}) * current_diff;

    assign delta = $signed({1'b0, head.ecd}) - $signed({1'b0, position_reg});

    always_comb begin
        position_next    = position_reg;
        turns_next       = turns_reg;
        speed_acc_next   = speed_acc_reg;
        current_acc_next = current_acc_reg;
        temp_next        = temp_reg;
        timeout_next     = timeout_reg;
        stop_next        = stop_reg;

        if (pop) begin
            unique case (head.op)
                OP_FRAME: begin
                    position_next    = head.ecd;
                    temp_next        = head.temp;
                    timeout_next     = cfg.timeout_reload;
                    // arithmetic shift is the floor of the division by 65536
                    speed_acc_next   = speed_acc_reg + speed_prod[43:16];
                    current_acc_next = current_acc_reg + current_prod[40:16];
                    if (delta > WRAP_THRESHOLD) begin
                        turns_next = turns_reg - 16'sd1;
                    end else if (delta < -WRAP_THRESHOLD) begin
                        turns_next = turns_reg + 16'sd1;
                    end
                end
                OP_TICK: begin
                    if (timeout_reg != 8'd0) begin
                        timeout_next = timeout_reg - 8'd1;
                    end else begin
                        stop_next = 1'b1;
                    end
                end
                OP_ENABLE: begin
                    stop_next = 1'b0;
                end
                OP_STOP: begin
                    stop_next = 1'b1;
                end
                default: begin
                    stop_next = stop_reg;
                end
            endcase
        end

        snap_next.position = position_next;
        snap_next.turns    = turns_next;
        snap_next.speed    = speed_acc_next[26:0];
        snap_next.current  = current_acc_next[23:0];
        snap_next.temp     = temp_next;
        snap_next.stopped  = stop_next;

        snap_valid_next = head_ready ? head_valid : snap_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg    <= 16'd0;
            turns_reg       <= 16'sd0;
            speed_acc_reg   <= 28'sd0;
            current_acc_reg <= 25'sd0;
            temp_reg        <= 8'd0;
            timeout_reg     <= RESET_TIMEOUT;
            stop_reg        <= 1'b0;
            snap_valid_reg  <= 1'b0;
        end else begin
            position_reg    <= position_next;
            turns_reg       <= turns_next;
            speed_acc_reg   <= speed_acc_next;
            current_acc_reg <= current_acc_next;
            temp_reg        <= temp_next;
            timeout_reg     <= timeout_next;
            stop_reg        <= stop_next;
            snap_valid_reg  <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

`default_nettype wire

// ----- rtl/mft_result.sv -----
`default_nettype none

module mft_result
    import mft_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [15:0]  angle_coef,
    input  wire logic         snap_valid,
    output logic              snap_ready,
    input  snap_t             snap,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [151:0]      m_tdata
);

    logic               m_tvalid_reg, m_tvalid_next;
    logic [151:0]       m_tdata_reg, m_tdata_next;
    logic [31:0]        single_angle;
    logic signed [24:0] turns_deg;
    logic [40:0]        multi_turn_angle;
    logic               load;

    assign snap_ready = !m_tvalid_reg || m_tready;
    assign load       = snap_valid && snap_ready;

    assign single_angle     = {16'd0, snap.position} * {16'd0, angle_coef};
    assign turns_deg        = {{9{snap.turns[15]}}, snap.turns} * DEG_PER_TURN;
    assign multi_turn_angle = {turns_deg, 16'd0} + {9'd0, single_angle};

    always_comb begin
        m_tdata_next = {3'd0, snap.stopped, snap.temp, snap.current, snap.speed,
                        multi_turn_angle, single_angle, snap.position};
        m_tvalid_next = snap_ready ? snap_valid : m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- rtl/motor_feedback_tracker_top.sv -----
`default_nettype none

// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tuser operation, s_tdata frame_payload
// m_        out  m_tvalid/m_tready    m_tdata result fields
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one beat per cycle sustained in both directions while m_tready is high; a beat
// passes the queue, state update, angle multiply and output register to the result
// filter loops (subtract, 17x29 or 17x26 multiply, add) close in the update cycle
// aresetn is synchronous; registers return to their defaults, the state to zero
// with the timeout count at two; cfg_ready is always high
// a stalled m_tready fills the output register, the update stage and the two-entry
// queue in turn before s_tready drops

module motor_feedback_tracker_top
    import mft_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // frame_payload
    input  wire logic [1:0]   s_tuser,   // operation
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // encoder_position, single_angle, multi_turn_angle, speed_filtered,
    // current_filtered, temperature, stopped, zero pad
    output logic [151:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [16:0]  cfg_data
);

    cfg_t  cfg_reg;
    cmd_t  head;
    logic  head_valid, head_ready;
    snap_t snap;
    logic  snap_valid, snap_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.angle_coef     <= RESET_ANGLE_COEF;
            cfg_reg.speed_smooth   <= RESET_SPEED_SMOOTH;
            cfg_reg.current_smooth <= RESET_CURRENT_SMOOTH;
            cfg_reg.timeout_reload <= RESET_TIMEOUT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ANGLE_COEF:     cfg_reg.angle_coef     <= cfg_data[15:0];
                CFG_SPEED_SMOOTH:   cfg_reg.speed_smooth   <= cfg_data;
                CFG_CURRENT_SMOOTH: cfg_reg.current_smooth <= cfg_data;
                CFG_TIMEOUT_RELOAD: cfg_reg.timeout_reload <= cfg_data[7:0];
                default:            cfg_reg.angle_coef     <= cfg_reg.angle_coef;
            endcase
        end
    end

    mft_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head       (head)
    );

    mft_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head       (head),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    mft_result u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .angle_coef (cfg_reg.angle_coef),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // a stop command always leaves the motor held
    a_stop_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && head_ready && head.op == OP_STOP) |=> snap.stopped)
        else $error("stop command did not set stopped");

    // an enable command always releases it
    a_enable_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && head_ready && head.op == OP_ENABLE) |=> !snap.stopped)
        else $error("enable command did not clear stopped");

    // a frame's encoder count shows up in the very next update
    a_frame_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && head_ready && head.op == OP_FRAME)
        |=> (snap_valid && snap.position == $past(head.ecd)))
        else $error("frame position not taken over");

    // non-frame commands leave the position alone
    a_hold_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && head_ready && head.op != OP_FRAME && snap_valid)
        |=> (snap.position == $past(snap.position)))
        else $error("position moved without a frame");

endmodule

`default_nettype wire
